// File: hdl/drs_pkg.sv
// Shared types, constants and codes for the discrete random sampler.
// No dependencies; every other file of the block uses this package.

package drs_pkg;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int PROB_W   = 49;
	localparam int TRIAL_W  = 10;
	localparam int SEED_W   = 32;
	localparam int SAMPLE_W = 10;
	localparam int STATE_W  = 48;
	localparam int HALF_W   = 24;

	// Configuration port
	localparam int CFG_DATA_W = 49;
	localparam int CFG_IDX_W  = 3;

	// Cap on Poisson draws per item
	localparam int MAX_DRAWS = 1023;
	localparam int DRAW_W = ($clog2(MAX_DRAWS + 1) > TRIAL_W) ?
		$clog2(MAX_DRAWS + 1) : TRIAL_W;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

	// Generator constants
	localparam logic [34:0]        LCG_MUL  = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0] LCG_ADD  = 48'h00000000000B;
	localparam logic [15:0]        SEED_LOW = 16'h330E;

	// Q48 fixed point
	localparam logic [PROB_W-1:0] ONE_Q48   = 49'h1_0000_0000_0000;
	localparam logic [PROB_W-1:0] HALF_Q48  = 49'h0_8000_0000_0000;
	localparam int                PROD_W    = 49;
	localparam int                ACC_W     = 50;
	localparam int                MUL_A_W   = 25;
	localparam int                MUL_P_W   = 49;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE  = 3'd0,
		REG_PROB  = 3'd1,
		REG_TRIAL = 3'd2,
		REG_LIMIT = 3'd3,
		REG_SEED  = 3'd4
	} reg_idx_t;

	// Distribution codes; code 3 makes no draw and yields zero
	typedef enum logic [MODE_W-1:0] {
		MODE_BERN  = 2'd0,
		MODE_BINOM = 2'd1,
		MODE_POIS  = 2'd2
	} mode_t;

	// Partial products of the Q48 multiply, in issue order
	typedef enum logic [1:0] {
		MUL_LL = 2'd0,
		MUL_LH = 2'd1,
		MUL_HL = 2'd2,
		MUL_HH = 2'd3
	} mul_step_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic      start;
		logic      lcg_a;
		logic      lcg_b;
		logic      cmp;
		logic      mul_en;
		mul_step_t mul_sel;
		logic      set_cap;
		logic      load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              trials_done;
		logic              prod_le_limit;
		logic              draws_at_cap;
	} sts_t;

endpackage

// File: hdl/drs_if.sv
// Valid/ready channel interfaces of the discrete random sampler.
// Depends on drs_pkg for field widths.

interface drs_req_if;
	logic valid;
	logic ready;
	logic reseed;

	modport source (output valid, output reseed, input ready);
	modport sink (input valid, input reseed, output ready);
endinterface

interface drs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [drs_pkg::SAMPLE_W-1:0]  sample;
	logic                          capped;

	modport source (output valid, output sample, output capped, input ready);
	modport sink (input valid, input sample, input capped, output ready);
endinterface

// File: hdl/discrete_random_sampler_unit.sv
// Top level of the discrete random sampler: drand48 generator feeding
// Bernoulli, binomial and Poisson draws. Depends on drs_pkg, drs_if,
// drs_ctrl and drs_datapath.
//
//   Channel  Direction  Payload           Transfer
//   req      in         reseed            valid & ready
//   rsp      out        sample, capped    valid & ready
//   cfg      in         index, data       cfg_wr_en
//
// One item at a time. Each generator step runs through LCG_A and LCG_B (the
// constant multiply is split in halves); each Poisson draw adds four passes
// through the shared 25x24 multiplier and one compare. A Poisson item makes
// at most 1023 draws. Reset restores the register defaults and the generator
// state at once. A result waits in its register while rsp is stalled; a new
// item is taken as soon as the previous one is in that register.

module discrete_random_sampler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [drs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [drs_pkg::CFG_DATA_W-1:0]  cfg_data,
	drs_req_if.sink                         req,
	drs_rsp_if.source                       rsp
);

	drs_pkg::cmd_t cmd;
	drs_pkg::sts_t sts;

	// Sequencing
	drs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Arithmetic and storage
	drs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.reseed    (req.reseed),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (rsp.sample),
		.capped    (rsp.capped)
	);

endmodule

// File: hdl/drs_datapath.sv
// Datapath: configuration registers, generator state, Q48 product, counters
// and result register. Depends on drs_pkg; driven by drs_ctrl commands.

module drs_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [drs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [drs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             reseed,
	input  drs_pkg::cmd_t                    cmd,
	output drs_pkg::sts_t                    sts,
	output logic [drs_pkg::SAMPLE_W-1:0]     sample,
	output logic                             capped
);

	// Configuration and generator state
	logic [drs_pkg::MODE_W-1:0]  mode_q;
	logic [drs_pkg::PROB_W-1:0]  prob_q;
	logic [drs_pkg::TRIAL_W-1:0] trial_q;
	logic [drs_pkg::PROB_W-1:0]  limit_q;
	logic [drs_pkg::SEED_W-1:0]  seed_q;
	logic [drs_pkg::STATE_W-1:0] lcg_state_q;

	// Working registers
	logic [drs_pkg::STATE_W-1:0] lcg_lo_q;
	logic [drs_pkg::PROD_W-1:0]  prod_q;
	logic [drs_pkg::ACC_W-1:0]   acc_q;
	logic [drs_pkg::DRAW_W-1:0]  draws_q;
	logic [drs_pkg::TRIAL_W-1:0] hits_q;
	logic                        cap_q;
	logic [drs_pkg::SAMPLE_W-1:0] sample_q;
	logic                        capped_q;

	logic [58:0]                   lcg_lo_full;
	logic [47:0]                   lcg_hi_full;
	logic [drs_pkg::STATE_W-1:0]   lcg_next;
	logic [drs_pkg::MUL_A_W-1:0]   mul_a;
	logic [drs_pkg::HALF_W-1:0]    mul_b;
	logic [drs_pkg::MUL_P_W-1:0]   mul_p;
	logic [drs_pkg::DRAW_W-1:0]    trial_target;
	logic [drs_pkg::DRAW_W-1:0]    pois_count;
	logic [drs_pkg::SAMPLE_W-1:0]  sample_d;
	logic                          capped_d;

	// Generator step split in two constant multiplies; the low-half product is registered first
	assign lcg_lo_full = lcg_state_q[drs_pkg::HALF_W-1:0] * drs_pkg::LCG_MUL;
	assign lcg_hi_full = lcg_state_q[drs_pkg::STATE_W-1:drs_pkg::HALF_W] *
		drs_pkg::LCG_MUL[drs_pkg::HALF_W-1:0];
	assign lcg_next = lcg_lo_q +
		{lcg_hi_full[drs_pkg::HALF_W-1:0], {drs_pkg::HALF_W{1'b0}}} + drs_pkg::LCG_ADD;

	// Operand select for the shared 25x24 multiplier
	always_comb begin
		case (cmd.mul_sel)
			drs_pkg::MUL_LL: begin
				mul_a = {1'b0, prod_q[drs_pkg::HALF_W-1:0]};
				mul_b = lcg_state_q[drs_pkg::HALF_W-1:0];
			end
			drs_pkg::MUL_LH: begin
				mul_a = {1'b0, prod_q[drs_pkg::HALF_W-1:0]};
				mul_b = lcg_state_q[drs_pkg::STATE_W-1:drs_pkg::HALF_W];
			end
			drs_pkg::MUL_HL: begin
				mul_a = prod_q[drs_pkg::PROD_W-1:drs_pkg::HALF_W];
				mul_b = lcg_state_q[drs_pkg::HALF_W-1:0];
			end
			default: begin
				mul_a = prod_q[drs_pkg::PROD_W-1:drs_pkg::HALF_W];
				mul_b = lcg_state_q[drs_pkg::STATE_W-1:drs_pkg::HALF_W];
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Bernoulli is a binomial of one trial
	assign trial_target = (mode_q == drs_pkg::MODE_BERN) ? drs_pkg::DRAW_W'(1) :
		drs_pkg::DRAW_W'(trial_q);

	assign sts.mode          = mode_q;
	assign sts.trials_done   = (draws_q == trial_target);
	assign sts.prod_le_limit = (prod_q <= limit_q);
	assign sts.draws_at_cap  = (draws_q == drs_pkg::DRAW_W'(drs_pkg::MAX_DRAWS));

	// Result formatting per distribution
	assign pois_count = draws_q - drs_pkg::DRAW_W'(1);
	always_comb begin
		case (mode_q)
			drs_pkg::MODE_BERN, drs_pkg::MODE_BINOM: begin
				sample_d = drs_pkg::SAMPLE_W'(hits_q);
				capped_d = 1'b0;
			end
			drs_pkg::MODE_POIS: begin
				if (pois_count > drs_pkg::DRAW_W'(drs_pkg::SAMPLE_MAX)) begin
					sample_d = drs_pkg::SAMPLE_W'(drs_pkg::SAMPLE_MAX);
					capped_d = 1'b1;
				end else begin
					sample_d = drs_pkg::SAMPLE_W'(pois_count);
					capped_d = cap_q;
				end
			end
			default: begin
				sample_d = '0;
				capped_d = 1'b0;
			end
		endcase
	end

	// Configuration registers and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= drs_pkg::MODE_BERN;
			prob_q      <= drs_pkg::HALF_Q48;
			trial_q     <= drs_pkg::TRIAL_W'(1);
			limit_q     <= '0;
			seed_q      <= '0;
			lcg_state_q <= {{drs_pkg::SEED_W{1'b0}}, drs_pkg::SEED_LOW};
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					drs_pkg::REG_MODE:  mode_q  <= cfg_data[drs_pkg::MODE_W-1:0];
					drs_pkg::REG_PROB:  prob_q  <= cfg_data[drs_pkg::PROB_W-1:0];
					drs_pkg::REG_TRIAL: trial_q <= cfg_data[drs_pkg::TRIAL_W-1:0];
					drs_pkg::REG_LIMIT: limit_q <= cfg_data[drs_pkg::PROB_W-1:0];
					drs_pkg::REG_SEED:  seed_q  <= cfg_data[drs_pkg::SEED_W-1:0];
					default: ;
				endcase
			end
			if (cmd.start && reseed) begin
				lcg_state_q <= {seed_q, drs_pkg::SEED_LOW};
			end else if (cmd.lcg_b) begin
				lcg_state_q <= lcg_next;
			end
		end
	end

	// Working registers of one item
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			prod_q  <= drs_pkg::ONE_Q48;
			draws_q <= '0;
			hits_q  <= '0;
			cap_q   <= 1'b0;
		end
		if (cmd.lcg_a) begin
			lcg_lo_q <= lcg_lo_full[drs_pkg::STATE_W-1:0];
		end
		if (cmd.lcg_b) begin
			draws_q <= draws_q + drs_pkg::DRAW_W'(1);
		end
		if (cmd.cmp && ({1'b0, lcg_state_q} < prob_q)) begin
			hits_q <= hits_q + drs_pkg::TRIAL_W'(1);
		end
		if (cmd.set_cap) begin
			cap_q <= 1'b1;
		end
		// Q48 product: low cross terms accumulate, high term closes the sum
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				drs_pkg::MUL_LL: acc_q <= drs_pkg::ACC_W'(mul_p >> drs_pkg::HALF_W);
				drs_pkg::MUL_LH, drs_pkg::MUL_HL: acc_q <= acc_q + drs_pkg::ACC_W'(mul_p);
				default: prod_q <= mul_p + drs_pkg::PROD_W'(acc_q >> drs_pkg::HALF_W);
			endcase
		end
		if (cmd.load_out) begin
			sample_q <= sample_d;
			capped_q <= capped_d;
		end
	end

	assign sample = sample_q;
	assign capped = capped_q;

endmodule

// File: hdl/drs_ctrl.sv
// Controller state machine: sequences draws, multiply passes and result hand-off.
// Depends on drs_pkg; steers drs_datapath through cmd_t and reads sts_t.

module drs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output drs_pkg::cmd_t cmd,
	input  drs_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LCG_A,
		ST_LCG_B,
		ST_CMP,
		ST_MUL_LL,
		ST_MUL_LH,
		ST_MUL_HL,
		ST_MUL_HH,
		ST_PCHECK,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result register can be loaded when empty or being emptied
	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	// Commands decoded from the current state
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = drs_pkg::MUL_LL;
		case (state_q)
			ST_IDLE:   cmd.start = req_valid;
			ST_LCG_A:  cmd.lcg_a = 1'b1;
			ST_LCG_B:  cmd.lcg_b = 1'b1;
			ST_CMP:    cmd.cmp   = 1'b1;
			ST_MUL_LL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = drs_pkg::MUL_LL;
			end
			ST_MUL_LH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = drs_pkg::MUL_LH;
			end
			ST_MUL_HL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = drs_pkg::MUL_HL;
			end
			ST_MUL_HH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = drs_pkg::MUL_HH;
			end
			ST_PCHECK: cmd.set_cap  = !sts.prod_le_limit && sts.draws_at_cap;
			ST_DONE:   cmd.load_out = out_free;
			default: ;
		endcase
	end

	// State register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Valid rises when a result is loaded and falls when the result is taken.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					case (sts.mode)
						drs_pkg::MODE_BERN, drs_pkg::MODE_BINOM:
							state_q <= sts.trials_done ? ST_DONE : ST_LCG_A;
						drs_pkg::MODE_POIS:
							state_q <= ST_LCG_A;
						default:
							state_q <= ST_DONE;
					endcase
				end
				ST_LCG_A: state_q <= ST_LCG_B;
				ST_LCG_B: begin
					if (sts.mode == drs_pkg::MODE_POIS) begin
						state_q <= ST_MUL_LL;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP:    state_q <= sts.trials_done ? ST_DONE : ST_LCG_A;
				ST_MUL_LL: state_q <= ST_MUL_LH;
				ST_MUL_LH: state_q <= ST_MUL_HL;
				ST_MUL_HL: state_q <= ST_MUL_HH;
				ST_MUL_HH: state_q <= ST_PCHECK;
				ST_PCHECK: begin
					if (sts.prod_le_limit || sts.draws_at_cap) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LCG_A;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the discrete random sampler: directed corner cases, then random
// configuration phases with items under random sender gaps and receiver stalls.
// Depends on drs_pkg, drs_if and the discrete_random_sampler_unit RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Mode code that the block leaves unused; it must give an all-zero result.
	localparam logic [drs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [drs_pkg::PROB_W-1:0] ALL_ONES_Q = '1;

	typedef struct packed {
		logic [drs_pkg::SAMPLE_W-1:0] sample;
		logic                         capped;
	} sample_rec_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [drs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [drs_pkg::CFG_DATA_W-1:0] cfg_data;

	drs_req_if req_ch ();
	drs_rsp_if rsp_ch ();

	discrete_random_sampler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Predictor copy of the registers and the generator state, at their reset values.
	logic [drs_pkg::MODE_W-1:0]  mode_reg  = drs_pkg::MODE_BERN;
	logic [drs_pkg::PROB_W-1:0]  prob_reg  = drs_pkg::HALF_Q48;
	logic [drs_pkg::TRIAL_W-1:0] trial_reg = 10'd1;
	logic [drs_pkg::PROB_W-1:0]  limit_reg = '0;
	logic [drs_pkg::SEED_W-1:0]  seed_reg  = '0;
	logic [drs_pkg::STATE_W-1:0] gen_state = {32'd0, drs_pkg::SEED_LOW};

	sample_rec_t pending_samples [$];
	int unsigned fail_count = 0;
	int unsigned burst_left = 0;

	// Receiver stall pattern, rotated every cycle and redrawn now and then.
	logic [15:0] stall_mask = '1;
	int unsigned stall_age = 0;

	sample_rec_t got_rec;
	sample_rec_t want_rec;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hang guard, far above the slowest correct run.
	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Advance the generator one step and return the Q48 draw.
	function automatic logic [drs_pkg::STATE_W-1:0] next_draw();
		gen_state = gen_state * drs_pkg::LCG_MUL + drs_pkg::LCG_ADD;
		return gen_state;
	endfunction

	// Work out the result of one item under the current configuration.
	function automatic sample_rec_t predict_sample(input bit reload);
		sample_rec_t                rec;
		logic [96:0]                full;
		logic [drs_pkg::PROB_W-1:0] prod;
		int unsigned                draws;
		bit                         hit;
		rec = '0;
		if (reload)
			gen_state = {seed_reg, drs_pkg::SEED_LOW};
		case (mode_reg)
			drs_pkg::MODE_BERN:
				rec.sample = drs_pkg::SAMPLE_W'(next_draw() < prob_reg);
			drs_pkg::MODE_BINOM: begin
				for (int unsigned i = 0; i < trial_reg; i++)
					if (next_draw() < prob_reg)
						rec.sample++;
			end
			drs_pkg::MODE_POIS: begin
				// Knuth's product method, truncated to Q48 after each multiply.
				prod = drs_pkg::ONE_Q48;
				draws = 0;
				hit = 1'b0;
				while (!hit && draws < drs_pkg::MAX_DRAWS) begin
					full = prod * next_draw();
					prod = full[96:48];
					draws++;
					if (prod <= limit_reg)
						hit = 1'b1;
				end
				rec.capped = !hit;
				if (draws - 1 > drs_pkg::SAMPLE_MAX) begin
					rec.sample = drs_pkg::SAMPLE_W'(drs_pkg::SAMPLE_MAX);
					rec.capped = 1'b1;
				end else begin
					rec.sample = drs_pkg::SAMPLE_W'(draws - 1);
				end
			end
			default: ;
		endcase
		return rec;
	endfunction

	function automatic void note_mismatch(input string field, input longint unsigned want,
			input longint unsigned got);
		if (fail_count < 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
		fail_count++;
	endfunction

	// Receiver: drive ready from the rotating stall pattern.
	always @(posedge clk) begin
		if (stall_age == 0) begin
			stall_age = $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0: stall_mask = '1;
				1: stall_mask = 16'($urandom);
				2: stall_mask = 16'($urandom | $urandom);
				default: stall_mask = 16'($urandom & $urandom);
			endcase
			if (stall_mask == '0)
				stall_mask = 16'h0001;
		end
		stall_age--;
		stall_mask = {stall_mask[0], stall_mask[15:1]};
		rsp_ch.ready <= stall_mask[0];
	end

	// Check each accepted result against the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_rec = '{rsp_ch.sample, rsp_ch.capped};
			if (pending_samples.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: unexpected result sample %0d capped %0d", $realtime,
						got_rec.sample, got_rec.capped);
				fail_count++;
			end else begin
				want_rec = pending_samples.pop_front();
				if (got_rec.sample !== want_rec.sample)
					note_mismatch("sample", want_rec.sample, got_rec.sample);
				if (got_rec.capped !== want_rec.capped)
					note_mismatch("capped", want_rec.capped, got_rec.capped);
			end
		end
	end

	// Stop sending and wait until every expected result has come back.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_samples.size() != 0)
			@(posedge clk);
	endtask

	// Send one item in bursts with random gaps; predict its result on acceptance.
	task automatic send_item(input bit reload);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid  <= 1'b1;
		req_ch.reseed <= reload;
		do @(posedge clk); while (!req_ch.ready);
		pending_samples.push_back(predict_sample(reload));
	endtask

	// Write all five registers once the block is idle; unused upper data bits sometimes get junk.
	task automatic set_config(input logic [drs_pkg::PROB_W-1:0] mode_v,
			input logic [drs_pkg::PROB_W-1:0] prob_v,
			input logic [drs_pkg::PROB_W-1:0] trial_v,
			input logic [drs_pkg::PROB_W-1:0] limit_v,
			input logic [drs_pkg::PROB_W-1:0] seed_v);
		drs_pkg::reg_idx_t              regs [5];
		int unsigned                    widths [5];
		logic [drs_pkg::CFG_DATA_W-1:0] vals [5];
		logic [drs_pkg::CFG_DATA_W-1:0] data;
		regs   = '{drs_pkg::REG_MODE, drs_pkg::REG_PROB, drs_pkg::REG_TRIAL,
			drs_pkg::REG_LIMIT, drs_pkg::REG_SEED};
		widths = '{drs_pkg::MODE_W, drs_pkg::PROB_W, drs_pkg::TRIAL_W, drs_pkg::PROB_W,
			drs_pkg::SEED_W};
		vals   = '{mode_v, prob_v, trial_v, limit_v, seed_v};
		wait_idle();
		// A write to an index with no register must change nothing.
		if ($urandom_range(0, 3) == 0) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= drs_pkg::REG_SEED + 3'($urandom_range(1, 3));
			cfg_data  <= drs_pkg::CFG_DATA_W'({$urandom, $urandom});
			@(posedge clk);
		end
		foreach (regs[i]) begin
			data = vals[i];
			if (widths[i] < drs_pkg::CFG_DATA_W && $urandom_range(0, 1) == 1)
				data = data | (drs_pkg::CFG_DATA_W'({$urandom, $urandom}) << widths[i]);
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= data;
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		mode_reg  = mode_v[drs_pkg::MODE_W-1:0];
		prob_reg  = prob_v;
		trial_reg = trial_v[drs_pkg::TRIAL_W-1:0];
		limit_reg = limit_v;
		seed_reg  = seed_v[drs_pkg::SEED_W-1:0];
	endtask

	// Register defaults straight after reset, with and without a reload of the seed.
	task automatic test_reset_defaults();
		send_item(1'b0);
		send_item(1'b0);
		send_item(1'b1);
	endtask

	// Bernoulli thresholds at zero, at one, above one and at the smallest step.
	task automatic test_bernoulli();
		set_config(drs_pkg::MODE_BERN, '0, 1, 0, 0);
		send_item(1'b0);
		set_config(drs_pkg::MODE_BERN, drs_pkg::ONE_Q48, 1, 0, 0);
		send_item(1'b0);
		set_config(drs_pkg::MODE_BERN, ALL_ONES_Q, 1, 0, 0);
		send_item(1'b1);
		set_config(drs_pkg::MODE_BERN, 1, 1, 0, 0);
		send_item(1'b0);
	endtask

	// Binomial with no trials, the most trials, and thresholds of one and zero.
	task automatic test_binomial();
		set_config(drs_pkg::MODE_BINOM, drs_pkg::HALF_Q48, 0, 0, 0);
		send_item(1'b0);
		set_config(drs_pkg::MODE_BINOM, drs_pkg::HALF_Q48, 1023, 0, 0);
		send_item(1'b1);
		set_config(drs_pkg::MODE_BINOM, drs_pkg::ONE_Q48, 5, 0, 0);
		send_item(1'b0);
		set_config(drs_pkg::MODE_BINOM, '0, 1023, 0, 0);
		send_item(1'b0);
	endtask

	// Poisson limits at and above one, at zero, at the smallest step and at one half.
	task automatic test_poisson();
		set_config(drs_pkg::MODE_POIS, drs_pkg::HALF_Q48, 1, drs_pkg::ONE_Q48, 0);
		send_item(1'b0);
		send_item(1'b0);
		set_config(drs_pkg::MODE_POIS, drs_pkg::HALF_Q48, 1, ALL_ONES_Q, 0);
		send_item(1'b1);
		set_config(drs_pkg::MODE_POIS, drs_pkg::HALF_Q48, 1, '0, 0);
		send_item(1'b0);
		send_item(1'b1);
		set_config(drs_pkg::MODE_POIS, drs_pkg::HALF_Q48, 1, 1, 0);
		send_item(1'b0);
		set_config(drs_pkg::MODE_POIS, drs_pkg::HALF_Q48, 1, drs_pkg::HALF_Q48, 0);
		send_item(1'b0);
	endtask

	// The unused mode makes no draw, with or without a reload.
	task automatic test_unused_mode();
		set_config(MODE_UNUSED, drs_pkg::HALF_Q48, 7, 0, 32'h1234_5678);
		send_item(1'b0);
		send_item(1'b1);
	endtask

	// A seed write alone leaves the generator; only a reload brings the new seed in.
	task automatic test_seed();
		set_config(drs_pkg::MODE_BERN, drs_pkg::HALF_Q48, 1, 0, 32'hFFFF_FFFF);
		send_item(1'b0);
		send_item(1'b1);
		set_config(drs_pkg::MODE_BINOM, drs_pkg::HALF_Q48, 16, 0, 0);
		send_item(1'b1);
		send_item(1'b0);
	endtask

	// Random configuration phases, each followed by a run of random items.
	task automatic test_random_phases();
		int unsigned                sent;
		int unsigned                count;
		logic [drs_pkg::PROB_W-1:0] m, p, n, lim;
		sent = 0;
		while (sent < 400) begin
			case ($urandom_range(0, 9))
				0, 1:    m = drs_pkg::MODE_BERN;
				2, 3, 4: m = drs_pkg::MODE_BINOM;
				9:       m = MODE_UNUSED;
				default: m = drs_pkg::MODE_POIS;
			endcase
			case ($urandom_range(0, 7))
				0:       p = '0;
				1:       p = drs_pkg::ONE_Q48;
				2:       p = drs_pkg::PROB_W'({$urandom, $urandom});
				default: p = drs_pkg::STATE_W'({$urandom, $urandom});
			endcase
			count = $urandom_range(8, 30);
			n = $urandom_range(0, 40);
			// Large trial counts are slow, so only a few items use them.
			if ($urandom_range(0, 19) == 0) begin
				n = $urandom_range(500, 1023);
				count = $urandom_range(2, 4);
			end
			case ($urandom_range(0, 9))
				0:       lim = '0;
				1:       lim = drs_pkg::ONE_Q48 + $urandom_range(0, 1000);
				2:       lim = 1;
				default: lim = drs_pkg::STATE_W'({$urandom, $urandom}) >> $urandom_range(0, 20);
			endcase
			set_config(m, p, n, lim, $urandom);
			repeat (count) send_item($urandom_range(0, 7) == 0);
			sent += count;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = drs_pkg::REG_MODE;
		cfg_data      = '0;
		req_ch.valid  = 1'b0;
		req_ch.reseed = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_bernoulli();
		test_binomial();
		test_poisson();
		test_unused_mode();
		test_seed();
		test_random_phases();

		wait_idle();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending_samples.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
